/* rtl/twh_pkg.sv */
// Package for the table driven word hash: widths, op codes, register
// indexes and rotate helpers. No dependencies.
package twh_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TAB_DEPTH   = 256;
    localparam int TAB_AW      = 8;
    localparam int PROG_W      = 64;
    localparam int CNT_W       = 5;
    localparam int CODE_W      = 4;
    localparam int OP_SLOTS    = 16;
    localparam int OP_IDX_W    = 4;
    localparam int MAX_OPS_DEF = 16;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CODE_W-1:0] t_code;

    // op codes
    localparam t_code OP_XOR  = 4'h0;
    localparam t_code OP_ADD  = 4'h1;
    localparam t_code OP_SUB  = 4'h2;
    localparam t_code OP_TABA = 4'h3;
    localparam t_code OP_TABB = 4'h4;
    localparam t_code OP_TABC = 4'h5;
    localparam t_code OP_ROTL = 4'h6;
    localparam t_code OP_ROTR = 4'h7;

    // configuration register indexes
    localparam logic REG_OP_PROGRAM = 1'b0;
    localparam logic REG_OP_COUNT   = 1'b1;

    localparam logic [CNT_W-1:0] OP_COUNT_RST = 5'd16;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << n;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    function automatic t_word rotr(input t_word x, input logic [4:0] n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} >> n;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

/* rtl/twh_in_if.sv */
// Input channel of the word hash: valid/ready plus one table write or data item.
// Depends on twh_pkg.
interface twh_in_if import twh_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                action;
    logic [TAB_AW-1:0]   table_index;
    t_word               table_value;
    t_word               data_word;
    logic                last;

    modport source (output valid, action, table_index, table_value, data_word, last,
                    input ready);
    modport sink   (input valid, action, table_index, table_value, data_word, last,
                    output ready);
endinterface

/* rtl/twh_out_if.sv */
// Output channel of the word hash: valid/ready plus the final hash value.
// Depends on twh_pkg.
interface twh_out_if import twh_pkg::*; ;
    logic  valid;
    logic  ready;
    t_word hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

/* rtl/twh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module twh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/table_driven_word_hash.sv */
// Top level of the table driven word hash: op sequencer, running hash and
// configuration registers. Depends on twh_pkg, twh_in_if, twh_out_if, twh_ram.

// A table write item is taken in the idle state and returns ready at once. A
// data word runs through each programmed op in turn: xor, add and subtract
// update the hash in the op state and other codes are no-ops; table xor makes four reads through the
// single read port of the code table RAM, one per cycle; rotate makes four
// rotates, one per cycle, each by the low five bits of one byte of the word. The
// block takes a new item while a finished hash still waits in the output
// register; a word marked last holds at its end until that register is free.
module table_driven_word_hash import twh_pkg::*; #(
    parameter int MAX_OPS = MAX_OPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    twh_in_if.sink            i_in,
    twh_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [PROG_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_OPS + 1);
    localparam logic [CNT_W-1:0] MaxOpsC = CNT_W'(MAX_OPS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_OP   = 4'b0010,
        ST_TAB  = 4'b0100,
        ST_ROT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_op_idx, n_op_idx;
    logic [1:0]         r_k, n_k;
    t_word              r_hash, n_hash;
    t_word              r_word;
    logic               r_last;
    logic [PROG_W-1:0]  r_op_program;
    logic [CNT_W-1:0]   r_op_count;
    logic               r_out_valid, n_out_valid;
    t_word              r_out_hash, n_out_hash;

    logic               w_accept;
    logic [CNT_W-1:0]   w_n_ops;
    t_code              w_code;
    logic [1:0]         w_byte_sel;
    logic [BYTE_W-1:0]  w_cur_byte;
    logic               w_rd_en;
    logic [TAB_AW-1:0]  w_rd_addr;
    t_word              w_rd_data;
    logic               w_out_free;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_n_ops    = (r_op_count > MaxOpsC) ? MaxOpsC : r_op_count;
    assign w_code     = r_op_program[CODE_W*OP_IDX_W'(r_op_idx) +: CODE_W];
    assign w_cur_byte = r_word[{r_k, 3'b000} +: BYTE_W];
    assign w_out_free = ~r_out_valid | o_out.ready;

    // byte whose table entry is fetched next: b0 from the op cycle, then k+1
    assign w_byte_sel = (r_state == ST_TAB) ? r_k + 2'd1 : 2'd0;
    assign w_rd_addr  = r_word[{w_byte_sel, 3'b000} +: BYTE_W];

    twh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TAB_DEPTH)
    ) u_code_table (
        .i_clk   (i_clk),
        .i_we    (w_accept & ~i_in.action),
        .i_waddr (i_in.table_index),
        .i_wdata (i_in.table_value),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_op_idx    = r_op_idx;
        n_k         = r_k;
        n_hash      = r_hash;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_hash  = r_out_hash;
        w_rd_en     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in.action) begin
                    n_op_idx = '0;
                    n_state  = ST_OP;
                end
            end
            ST_OP: begin
                if (CNT_W'(r_op_idx) == w_n_ops) begin
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_hash  = r_hash;
                        n_hash      = '0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_k = 2'd0;
                    case (w_code)
                        OP_XOR: begin
                            n_hash   = r_hash ^ r_word;
                            n_op_idx = r_op_idx + 1'b1;
                        end
                        OP_ADD: begin
                            n_hash   = r_hash + r_word;
                            n_op_idx = r_op_idx + 1'b1;
                        end
                        OP_SUB: begin
                            n_hash   = r_hash - r_word;
                            n_op_idx = r_op_idx + 1'b1;
                        end
                        OP_TABA, OP_TABB, OP_TABC: begin
                            w_rd_en = 1'b1;
                            n_state = ST_TAB;
                        end
                        OP_ROTL, OP_ROTR: begin
                            n_state = ST_ROT;
                        end
                        default: begin
                            n_op_idx = r_op_idx + 1'b1;
                        end
                    endcase
                end
            end
            ST_TAB: begin
                // entry for byte k arrives now; fetch the next one behind it
                n_hash = r_hash ^ w_rd_data;
                if (r_k == 2'd3) begin
                    n_op_idx = r_op_idx + 1'b1;
                    n_state  = ST_OP;
                end else begin
                    w_rd_en = 1'b1;
                    n_k     = r_k + 2'd1;
                end
            end
            ST_ROT: begin
                if (w_code == OP_ROTL) begin
                    n_hash = rotl(r_hash, w_cur_byte[4:0]);
                end else begin
                    n_hash = rotr(r_hash, w_cur_byte[4:0]);
                end
                if (r_k == 2'd3) begin
                    n_op_idx = r_op_idx + 1'b1;
                    n_state  = ST_OP;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_op_idx     <= '0;
            r_k          <= '0;
            r_hash       <= '0;
            r_out_valid  <= 1'b0;
            r_op_program <= '0;
            r_op_count   <= OP_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_op_idx    <= n_op_idx;
            r_k         <= n_k;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OP_PROGRAM: r_op_program <= i_cfg_data;
                    REG_OP_COUNT:   r_op_count   <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hash <= n_out_hash;
        if (w_accept && i_in.action) begin
            r_word <= i_in.data_word;
            r_last <= i_in.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

endmodule
